### rtl/trial_division_prime_test_unit_macros.svh
// Assertion macros shared by the trial division prime test checker
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tdpt_pkg.sv
// Shared types and constants for the trial division prime test unit
package tdpt_pkg;

    typedef logic [1:0] verdict_t;

    localparam verdict_t VERDICT_PRIME     = 2'd0;
    localparam verdict_t VERDICT_COMPOSITE = 2'd1;
    localparam verdict_t VERDICT_NEITHER   = 2'd2;

    localparam int FIRST_PRIME       = 2;
    localparam int FIRST_ODD_DIVISOR = 3;
    localparam int DIVISOR_STEP      = 2;

endpackage

### rtl/tdpt_remainder_unit.sv
// Serial restoring divider: one quotient bit per cycle, gives quotient and remainder
module tdpt_remainder_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [VALUE_WIDTH-1:0] remainder
);
    import tdpt_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH:0]   diff;
    logic                   qbit;

    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract where it fits
            rem_next = qbit ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], qbit};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

### rtl/trial_division_prime_test_unit.sv
// Negative values, 0, 1, 2 and even values get their verdict in the cycle after the input transfer.
// Odd values above 2 try the odd divisors 3, 5, ... in turn until one divides n or exceeds n / divisor.
// Each divisor passes through a load step, the serial divider and a decision step.
// One value at a time; the next is taken once the verdict has been transferred.
// Reset (rst_n, asynchronous, active low) empties the unit; no result is pending.
module trial_division_prime_test_unit #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [VALUE_WIDTH-1:0] number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output tdpt_pkg::verdict_t            verdict
);
    import tdpt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic                   out_valid_reg, out_valid_next;
    verdict_t               verdict_reg, verdict_next;

    logic [VALUE_WIDTH-1:0] n_in;
    logic                   in_xfer;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quot;
    logic [VALUE_WIDTH-1:0] div_rem;

    assign n_in     = number;
    assign in_stall = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_xfer  = in_valid && !in_stall;

    tdpt_remainder_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (n_reg),
        .divisor   (d_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        out_valid_next = out_valid_reg;
        verdict_next   = verdict_reg;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    n_next = n_in;
                    d_next = VALUE_WIDTH'(FIRST_ODD_DIVISOR);
                    if (n_in[VALUE_WIDTH-1] || (n_in[VALUE_WIDTH-1:1] == '0))
                    begin
                        out_valid_next = 1'b1;
                        verdict_next   = VERDICT_NEITHER;
                    end
                    else if (n_in == VALUE_WIDTH'(FIRST_PRIME))
                    begin
                        out_valid_next = 1'b1;
                        verdict_next   = VERDICT_PRIME;
                    end
                    else if (!n_in[0])
                    begin
                        out_valid_next = 1'b1;
                        verdict_next   = VERDICT_COMPOSITE;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    // divisor past n / divisor means no factor up to the root
                    if (d_reg > div_quot)
                    begin
                        out_valid_next = 1'b1;
                        verdict_next   = VERDICT_PRIME;
                        state_next     = ST_IDLE;
                    end
                    else if (div_rem == '0)
                    begin
                        out_valid_next = 1'b1;
                        verdict_next   = VERDICT_COMPOSITE;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        d_next     = d_reg + VALUE_WIDTH'(DIVISOR_STEP);
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        d_reg       <= d_next;
        verdict_reg <= verdict_next;
    end

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

endmodule

### rtl/tdpt_checker.sv
// Port-level checks for the trial division prime test unit, bound to the top level
`include "trial_division_prime_test_unit_macros.svh"

module tdpt_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic signed [VALUE_WIDTH-1:0] number,
    input logic                          out_valid,
    input logic                          out_stall,
    input tdpt_pkg::verdict_t            verdict
);
    import tdpt_pkg::*;

    // hold a stalled result
    `TDPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(verdict), "stalled verdict changed")

    `TDPT_ASSERT_NOW(a_code_legal, out_valid, (verdict == VERDICT_PRIME) || (verdict == VERDICT_COMPOSITE) || (verdict == VERDICT_NEITHER), "unused verdict code")

    // one value in flight: no new transfer while a verdict waits
    `TDPT_ASSERT_NOW(a_single_item, out_valid, in_stall, "input open while verdict pending")

    `TDPT_ASSERT_NEXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input open right after transfer")

    // negative values are classified at once
    `TDPT_ASSERT_NEXT(a_negative_fast, in_valid && !in_stall && number[VALUE_WIDTH-1], out_valid && (verdict == VERDICT_NEITHER), "negative value not rejected")

endmodule

bind trial_division_prime_test_unit tdpt_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_tdpt_checker (.*);
